FILE: src/sbba_pkg.sv
// ----------------------------------------------------------------------------
// sbba_pkg
// shared types and constants for the staging block bump allocator
// ----------------------------------------------------------------------------
package sbba_pkg;

    localparam int NUM_BLOCKS  = 16;
    localparam int IDX_W       = $clog2(NUM_BLOCKS);
    localparam int QCNT_W      = $clog2(NUM_BLOCKS + 1);
    localparam int ALIGN_BYTES = 16;
    localparam int ALIGN_W     = $clog2(ALIGN_BYTES);

    localparam int OFF_W  = 31;
    localparam int CNT_W  = 27;
    localparam int REQ_W  = 32;
    localparam int SZ_W   = 33;
    localparam int SUM_W  = SZ_W + 1;

    localparam logic [OFF_W-1:0] BS_RESET = OFF_W'(64 * 1024 * 1024);
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        ST_GRANT    = 2'd0,
        ST_BYPASS   = 2'd1,
        ST_NO_BLOCK = 2'd2,
        ST_RELEASED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REL_CHK,
        S_ACT_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NEW,
        S_RESP
    } state_t;

    // one block's bookkeeping, as kept in the state memory
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [OFF_W-1:0] off;
    } entry_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

endpackage

FILE: src/staging_block_bump_allocator_top.sv
// ----------------------------------------------------------------------------
// staging_block_bump_allocator_top
// suballocates aligned staging space from a pool of equal-size blocks
// ----------------------------------------------------------------------------
// One request is handled at a time. Per-block offset and outstanding count
// live in a single-port state memory with a registered read; every lookup
// takes a read state and a check state, and a bypass acquire or bypass
// release needs no lookup. An acquire that must look for a new block scans
// the draining blocks (at most NUM_BLOCKS) and creates a new one only if none
// is idle. The result sits in an output register, so a request can be taken
// while the previous result still waits. The user must write the block size
// register through the cfg channel only while no request is in flight; the
// block itself does not enforce this. The memory needs no clearing pass after
// reset.
module staging_block_bump_allocator_top
    import sbba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // request_size[31:0], release_block[35:32], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op[0], release_adhoc[1]
    input  logic [IN_USER_W-1:0]  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // block_index[3:0], offset[34:4], granted_size[67:35], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [OUT_USER_W-1:0] m_tuser,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [OFF_W-1:0]      cfg_data
);

    // state memory
    entry_t                  mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]   ent_vld_reg;
    entry_t                  mem_q;
    logic                    mem_q_vld;
    logic                    mem_re;
    logic [IDX_W-1:0]        mem_raddr;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    entry_t                  mem_wdata;
    entry_t                  ent;

    // draining queue
    logic [IDX_W-1:0]        q_reg [NUM_BLOCKS];
    logic [IDX_W-1:0]        q_next [NUM_BLOCKS];

    state_t                  state_reg, state_next;
    logic [OFF_W-1:0]        bs_reg;
    logic                    act_vld_reg, act_vld_next;
    logic [IDX_W-1:0]        act_idx_reg, act_idx_next;
    logic [QCNT_W-1:0]       dcnt_reg, dcnt_next;
    logic [QCNT_W-1:0]       created_reg, created_next;
    logic [QCNT_W-1:0]       scan_reg, scan_next;
    logic [SZ_W-1:0]         sz_reg, sz_next;
    logic [IDX_W-1:0]        rb_reg, rb_next;

    status_t                 res_st_reg, res_st_next;
    logic [IDX_W-1:0]        res_idx_reg, res_idx_next;
    logic [OFF_W-1:0]        res_off_reg, res_off_next;
    logic [SZ_W-1:0]         res_sz_reg, res_sz_next;

    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    status_t                 m_st_reg, m_st_next;

    logic [REQ_W-1:0]        in_req;
    logic [IDX_W-1:0]        in_rb;
    logic                    in_op;
    logic                    in_adhoc;
    logic [SZ_W-1:0]         in_rnd;
    logic [SZ_W-1:0]         in_sz;
    logic                    in_bypass;
    logic [SUM_W-1:0]        fit_sum;
    logic                    fits;
    logic [IDX_W-1:0]        scan_blk;

    assign in_req   = s_tdata[REQ_W-1:0];
    assign in_rb    = s_tdata[REQ_W +: IDX_W];
    assign in_op    = s_tuser[0];
    assign in_adhoc = s_tuser[1];

    // round up to the alignment
    assign in_rnd    = {1'b0, in_req} + SZ_W'(ALIGN_BYTES - 1);
    assign in_sz     = {in_rnd[SZ_W-1:ALIGN_W], ALIGN_W'(0)};
    assign in_bypass = in_sz > ({(SZ_W - OFF_W)'(0), bs_reg} >> 1);

    // an entry never written reads as zero offset and zero count
    assign ent      = mem_q_vld ? mem_q : '0;
    assign fit_sum  = {(SUM_W - OFF_W)'(0), ent.off} + {1'b0, sz_reg};
    assign fits     = fit_sum <= {(SUM_W - OFF_W)'(0), bs_reg};
    assign scan_blk = q_reg[scan_reg[IDX_W-1:0]];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_st_reg;

    always_comb
    begin
        state_next    = state_reg;
        act_vld_next  = act_vld_reg;
        act_idx_next  = act_idx_reg;
        dcnt_next     = dcnt_reg;
        created_next  = created_reg;
        scan_next     = scan_reg;
        sz_next       = sz_reg;
        rb_next       = rb_reg;
        res_st_next   = res_st_reg;
        res_idx_next  = res_idx_reg;
        res_off_next  = res_off_reg;
        res_sz_next   = res_sz_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_st_next     = m_st_reg;
        q_next        = q_reg;
        mem_re        = 1'b0;
        mem_raddr     = act_idx_reg;
        mem_we        = 1'b0;
        mem_waddr     = act_idx_reg;
        mem_wdata     = ent;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    sz_next = in_sz;
                    rb_next = in_rb;
                    if (in_op)
                    begin
                        res_st_next  = ST_RELEASED;
                        res_idx_next = in_rb;
                        res_off_next = '0;
                        res_sz_next  = '0;
                        if (!in_adhoc)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = in_rb;
                            state_next = S_REL_CHK;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    else
                    begin
                        res_idx_next = '0;
                        res_off_next = '0;
                        res_sz_next  = in_sz;
                        if (in_bypass)
                        begin
                            res_st_next = ST_BYPASS;
                            state_next  = S_RESP;
                        end
                        else if (act_vld_reg)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = act_idx_reg;
                            state_next = S_ACT_CHK;
                        end
                        else
                        begin
                            scan_next  = '0;
                            state_next = S_SCAN_RD;
                        end
                    end
                end
            end

            S_REL_CHK:
            begin
                if (ent.cnt != '0)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = rb_reg;
                    mem_wdata.off = ent.off;
                    mem_wdata.cnt = ent.cnt - CNT_W'(1);
                end
                state_next = S_RESP;
            end

            S_ACT_CHK:
            begin
                if (fits || ent.cnt == '0)
                begin
                    // rewind when nothing is outstanding; size is at most half a block
                    mem_we        = 1'b1;
                    mem_waddr     = act_idx_reg;
                    mem_wdata.cnt = sat_inc(ent.cnt);
                    res_st_next   = ST_GRANT;
                    res_idx_next  = act_idx_reg;
                    if (fits)
                    begin
                        mem_wdata.off = fit_sum[OFF_W-1:0];
                        res_off_next  = ent.off;
                    end
                    else
                    begin
                        mem_wdata.off = sz_reg[OFF_W-1:0];
                        res_off_next  = '0;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    if (dcnt_reg < QCNT_W'(NUM_BLOCKS))
                    begin
                        q_next[dcnt_reg[IDX_W-1:0]] = act_idx_reg;
                        dcnt_next = dcnt_reg + QCNT_W'(1);
                    end
                    act_vld_next = 1'b0;
                    scan_next    = '0;
                    state_next   = S_SCAN_RD;
                end
            end

            S_SCAN_RD:
            begin
                if (scan_reg < dcnt_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = scan_blk;
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    state_next = S_NEW;
                end
            end

            S_SCAN_CHK:
            begin
                if (ent.cnt == '0)
                begin
                    // take the oldest idle draining block and close the gap
                    for (int i = 0; i < NUM_BLOCKS - 1; i++)
                    begin
                        if (QCNT_W'(i) >= scan_reg)
                        begin
                            q_next[i] = q_reg[i + 1];
                        end
                    end
                    dcnt_next     = dcnt_reg - QCNT_W'(1);
                    act_vld_next  = 1'b1;
                    act_idx_next  = scan_blk;
                    mem_we        = 1'b1;
                    mem_waddr     = scan_blk;
                    mem_wdata.off = sz_reg[OFF_W-1:0];
                    mem_wdata.cnt = CNT_W'(1);
                    res_st_next   = ST_GRANT;
                    res_idx_next  = scan_blk;
                    res_off_next  = '0;
                    state_next    = S_RESP;
                end
                else
                begin
                    scan_next  = scan_reg + QCNT_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_NEW:
            begin
                if (created_reg < QCNT_W'(NUM_BLOCKS))
                begin
                    act_vld_next  = 1'b1;
                    act_idx_next  = created_reg[IDX_W-1:0];
                    created_next  = created_reg + QCNT_W'(1);
                    mem_we        = 1'b1;
                    mem_waddr     = created_reg[IDX_W-1:0];
                    mem_wdata.off = sz_reg[OFF_W-1:0];
                    mem_wdata.cnt = CNT_W'(1);
                    res_st_next   = ST_GRANT;
                    res_idx_next  = created_reg[IDX_W-1:0];
                    res_off_next  = '0;
                end
                else
                begin
                    res_st_next = ST_NO_BLOCK;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_st_next     = res_st_reg;
                    m_tdata_next  = {(OUT_DATA_W - SZ_W - OFF_W - IDX_W)'(0),
                                     res_sz_reg, res_off_reg, res_idx_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            bs_reg       <= BS_RESET;
            act_vld_reg  <= 1'b0;
            act_idx_reg  <= '0;
            dcnt_reg     <= '0;
            created_reg  <= '0;
            scan_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            ent_vld_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            act_vld_reg  <= act_vld_next;
            act_idx_reg  <= act_idx_next;
            dcnt_reg     <= dcnt_next;
            created_reg  <= created_next;
            scan_reg     <= scan_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid)
            begin
                bs_reg <= cfg_data;
            end
            if (mem_we)
            begin
                ent_vld_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sz_reg      <= sz_next;
        rb_reg      <= rb_next;
        res_st_reg  <= res_st_next;
        res_idx_reg <= res_idx_next;
        res_off_reg <= res_off_next;
        res_sz_reg  <= res_sz_next;
        m_tdata_reg <= m_tdata_next;
        m_st_reg    <= m_st_next;
        q_reg       <= q_next;
    end

    // single-port state memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q     <= mem[mem_raddr];
            mem_q_vld <= ent_vld_reg[mem_raddr];
        end
    end

    a_dcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= QCNT_W'(NUM_BLOCKS))
        else $error("draining queue count out of range");

    a_created_bound: assert property (@(posedge clk) disable iff (!rst_n)
        created_reg <= QCNT_W'(NUM_BLOCKS))
        else $error("created block count out of range");

    a_active_created: assert property (@(posedge clk) disable iff (!rst_n)
        act_vld_reg |-> ({1'b0, act_idx_reg} < created_reg))
        else $error("active block was never created");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != S_IDLE && state_reg != S_RESP))
        else $error("state memory written outside a lookup");

endmodule
